// File: rtl/ufrs_pkg.sv
// Shared types and constants for the union-find store with rank and size.
// Used by every module and interface of the block; depends on nothing.
`default_nettype none

package ufrs_pkg;

	// Node count is a power of two; node indexes wrap by dropping high bits.
	localparam int NODE_W     = 10;
	localparam int NODE_COUNT = 1 << NODE_W;
	localparam int RANK_W     = $clog2(NODE_W + 1);
	localparam int SIZE_W     = $clog2(NODE_COUNT + 1);

	// Fixed widths of the word fields on the ports
	localparam int FIELD_NODE_W = 10;
	localparam int FIELD_SIZE_W = 11;
	localparam int SIZE_MAX_OUT = (1 << FIELD_SIZE_W) - 1;

	typedef logic [NODE_W-1:0] node_t;
	typedef logic [RANK_W-1:0] rank_t;
	typedef logic [SIZE_W-1:0] size_t;

	typedef struct packed {
		node_t parent;
		rank_t rank;
		size_t size;
	} entry_t;

	typedef struct packed {
		logic   re;
		node_t  raddr;
		logic   we;
		node_t  waddr;
		entry_t wdata;
	} mem_req_t;

	typedef struct packed {
		logic  joined;
		node_t root;
		size_t size;
	} result_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_START,
		ST_CLIMB,
		ST_COMPRESS,
		ST_LINK_LOSER,
		ST_LINK_WINNER,
		ST_RESULT
	} state_t;

	typedef enum logic [1:0] {
		PH_A,
		PH_B,
		PH_FINAL
	} phase_t;

endpackage

`default_nettype wire

// File: rtl/ufrs_req_if.sv
// Request channel: valid/ready handshake carrying one operation word.
// Depends on ufrs_pkg for field widths.
`default_nettype none

interface ufrs_req_if;
	logic                                valid;
	logic                                ready;
	logic                                operation;
	logic [ufrs_pkg::FIELD_NODE_W-1:0] first_node;
	logic [ufrs_pkg::FIELD_NODE_W-1:0] second_node;

	modport source (output valid, output operation, output first_node,
		output second_node, input ready);
	modport sink (input valid, input operation, input first_node,
		input second_node, output ready);
endinterface

`default_nettype wire

// File: rtl/ufrs_rsp_if.sv
// Response channel: valid/ready handshake carrying one result word.
// Depends on ufrs_pkg for field widths.
`default_nettype none

interface ufrs_rsp_if;
	logic                                valid;
	logic                                ready;
	logic                                already_joined;
	logic [ufrs_pkg::FIELD_NODE_W-1:0] first_root;
	logic [ufrs_pkg::FIELD_SIZE_W-1:0] first_set_size;

	modport source (output valid, output already_joined, output first_root,
		output first_set_size, input ready);
	modport sink (input valid, input already_joined, input first_root,
		input first_set_size, output ready);
endinterface

`default_nettype wire

// File: rtl/ufrs_store.sv
// Node table: one write port and one registered read port, one entry per node.
// Depends on ufrs_pkg for the entry and request types.
`default_nettype none

module ufrs_store (
	input  wire logic               clk,
	input  wire ufrs_pkg::mem_req_t req,
	output ufrs_pkg::entry_t        rd_data
);

	ufrs_pkg::entry_t mem [ufrs_pkg::NODE_COUNT];
	ufrs_pkg::entry_t rd_q;

	// Write port
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (req.re) begin
			rd_q <= mem[req.raddr];
		end
	end

	assign rd_data = rd_q;

endmodule

`default_nettype wire

// File: rtl/ufrs_seq.sv
// Sequencer: clearing pass, two finds with path compression, link, final find.
// Depends on ufrs_pkg; drives the node table through a mem_req_t.
`default_nettype none

module ufrs_seq (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               op,
	input  wire ufrs_pkg::node_t    node_a,
	input  wire ufrs_pkg::node_t    node_b,
	input  wire logic               out_free,
	output logic                    res_valid,
	output ufrs_pkg::result_t       res,
	output ufrs_pkg::mem_req_t      mem_req,
	input  wire ufrs_pkg::entry_t   rd_data
);

	ufrs_pkg::state_t state_q, state_d;
	ufrs_pkg::phase_t phase_q;
	ufrs_pkg::node_t  clr_q;

	logic            op_q;
	logic            joined_q;
	ufrs_pkg::node_t a_q, b_q, node_q, cur_q, walk_q, top_q;
	ufrs_pkg::node_t ra_q, rb_q, res_root_q;
	ufrs_pkg::rank_t rank_a_q, rank_b_q, top_rank_q;
	ufrs_pkg::size_t size_a_q, size_b_q, top_size_q, res_size_q;

	logic            is_root;
	logic            phase_end;
	logic            do_link;
	logic            a_wins;
	logic            rank_tie;
	ufrs_pkg::node_t found_root;
	ufrs_pkg::rank_t found_rank;
	ufrs_pkg::size_t found_size;
	ufrs_pkg::node_t winner, loser;
	ufrs_pkg::entry_t loser_entry, winner_entry;

	// Root detection and the root that a finished find hands on
	always_comb begin
		is_root    = (rd_data.parent == cur_q);
		found_root = (state_q == ufrs_pkg::ST_CLIMB) ? cur_q : top_q;
		found_rank = (state_q == ufrs_pkg::ST_CLIMB) ? rd_data.rank : top_rank_q;
		found_size = (state_q == ufrs_pkg::ST_CLIMB) ? rd_data.size : top_size_q;
		phase_end  = 1'b0;
		case (state_q)
			ufrs_pkg::ST_CLIMB:    phase_end = is_root && (node_q == cur_q);
			ufrs_pkg::ST_COMPRESS: phase_end = (rd_data.parent == top_q);
			default:               phase_end = 1'b0;
		endcase
		do_link = op_q && (ra_q != found_root);
	end

	// Union by rank: lower rank hangs under the other, tie goes to the second root
	always_comb begin
		a_wins   = (rank_a_q > rank_b_q);
		rank_tie = (rank_a_q == rank_b_q);
		winner   = a_wins ? ra_q : rb_q;
		loser    = a_wins ? rb_q : ra_q;
		loser_entry.parent  = winner;
		loser_entry.rank    = a_wins ? rank_b_q : rank_a_q;
		loser_entry.size    = a_wins ? size_b_q : size_a_q;
		winner_entry.parent = winner;
		winner_entry.rank   = a_wins ? rank_a_q
			: (rank_tie ? ufrs_pkg::rank_t'(rank_b_q + 1'b1) : rank_b_q);
		winner_entry.size   = ufrs_pkg::size_t'(size_a_q + size_b_q);
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ufrs_pkg::ST_CLEAR: begin
				if (clr_q == '1) state_d = ufrs_pkg::ST_IDLE;
			end
			ufrs_pkg::ST_IDLE: begin
				if (in_valid) state_d = ufrs_pkg::ST_START;
			end
			ufrs_pkg::ST_START: begin
				state_d = ufrs_pkg::ST_CLIMB;
			end
			ufrs_pkg::ST_CLIMB, ufrs_pkg::ST_COMPRESS: begin
				if (phase_end) begin
					case (phase_q)
						ufrs_pkg::PH_A: state_d = ufrs_pkg::ST_START;
						ufrs_pkg::PH_B: state_d = do_link ? ufrs_pkg::ST_LINK_LOSER
							: ufrs_pkg::ST_RESULT;
						default:        state_d = ufrs_pkg::ST_RESULT;
					endcase
				end else if (state_q == ufrs_pkg::ST_CLIMB && is_root) begin
					state_d = ufrs_pkg::ST_COMPRESS;
				end
			end
			ufrs_pkg::ST_LINK_LOSER: begin
				state_d = ufrs_pkg::ST_LINK_WINNER;
			end
			ufrs_pkg::ST_LINK_WINNER: begin
				state_d = ufrs_pkg::ST_START;
			end
			ufrs_pkg::ST_RESULT: begin
				if (out_free) state_d = ufrs_pkg::ST_IDLE;
			end
			default: begin
				state_d = ufrs_pkg::ST_CLEAR;
			end
		endcase
	end

	// Outputs: table accesses, handshake and result strobe
	always_comb begin
		mem_req   = '0;
		in_ready  = 1'b0;
		res_valid = 1'b0;
		case (state_q)
			ufrs_pkg::ST_CLEAR: begin
				mem_req.we           = 1'b1;
				mem_req.waddr        = clr_q;
				mem_req.wdata.parent = clr_q;
				mem_req.wdata.rank   = '0;
				mem_req.wdata.size   = ufrs_pkg::size_t'(1);
			end
			ufrs_pkg::ST_IDLE: begin
				in_ready = 1'b1;
			end
			ufrs_pkg::ST_START: begin
				mem_req.re    = 1'b1;
				mem_req.raddr = node_q;
			end
			ufrs_pkg::ST_CLIMB: begin
				if (!is_root) begin
					mem_req.re    = 1'b1;
					mem_req.raddr = rd_data.parent;
				end else if (node_q != cur_q) begin
					mem_req.re    = 1'b1;
					mem_req.raddr = node_q;
				end
			end
			ufrs_pkg::ST_COMPRESS: begin
				mem_req.we           = 1'b1;
				mem_req.waddr        = walk_q;
				mem_req.wdata.parent = top_q;
				mem_req.wdata.rank   = rd_data.rank;
				mem_req.wdata.size   = rd_data.size;
				if (rd_data.parent != top_q) begin
					mem_req.re    = 1'b1;
					mem_req.raddr = rd_data.parent;
				end
			end
			ufrs_pkg::ST_LINK_LOSER: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = loser;
				mem_req.wdata = loser_entry;
			end
			ufrs_pkg::ST_LINK_WINNER: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = winner;
				mem_req.wdata = winner_entry;
			end
			ufrs_pkg::ST_RESULT: begin
				res_valid = out_free;
			end
			default: begin
				mem_req = '0;
			end
		endcase
	end

	assign res.joined = joined_q;
	assign res.root   = res_root_q;
	assign res.size   = res_size_q;

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ufrs_pkg::ST_CLEAR;
			phase_q <= ufrs_pkg::PH_A;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ufrs_pkg::ST_CLEAR) clr_q <= ufrs_pkg::node_t'(clr_q + 1'b1);
			if (state_q == ufrs_pkg::ST_IDLE && in_valid) phase_q <= ufrs_pkg::PH_A;
			if (phase_end) begin
				case (phase_q)
					ufrs_pkg::PH_A: phase_q <= ufrs_pkg::PH_B;
					ufrs_pkg::PH_B: phase_q <= ufrs_pkg::PH_FINAL;
					default:        phase_q <= ufrs_pkg::PH_FINAL;
				endcase
			end
		end
	end

	// Walk pointers, captured roots and the result
	always_ff @(posedge clk) begin
		case (state_q)
			ufrs_pkg::ST_IDLE: begin
				if (in_valid) begin
					op_q   <= op;
					a_q    <= node_a;
					b_q    <= node_b;
					node_q <= node_a;
				end
			end
			ufrs_pkg::ST_START: begin
				cur_q <= node_q;
			end
			ufrs_pkg::ST_CLIMB: begin
				if (is_root) begin
					top_q      <= cur_q;
					top_rank_q <= rd_data.rank;
					top_size_q <= rd_data.size;
					walk_q     <= node_q;
				end else begin
					cur_q <= rd_data.parent;
				end
			end
			ufrs_pkg::ST_COMPRESS: begin
				walk_q <= rd_data.parent;
			end
			default: begin
			end
		endcase
		if (phase_end) begin
			case (phase_q)
				ufrs_pkg::PH_A: begin
					ra_q     <= found_root;
					rank_a_q <= found_rank;
					size_a_q <= found_size;
					node_q   <= b_q;
				end
				ufrs_pkg::PH_B: begin
					rb_q       <= found_root;
					rank_b_q   <= found_rank;
					size_b_q   <= found_size;
					joined_q   <= (ra_q == found_root);
					node_q     <= a_q;
					res_root_q <= ra_q;
					res_size_q <= size_a_q;
				end
				default: begin
					res_root_q <= found_root;
					res_size_q <= found_size;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// File: rtl/union_find_rank_size_core.sv
// Each find climbs to the root, then relinks the path; an item runs two finds, plus
// two link writes and a third find on a unite that joins, and accept and result
// states; one item at a time, a new word taken once the result is registered.
// The walk over the node table, with one read and one write port, sets the rate: one link per cycle.
// Reset: a clearing pass over all 1024 entries initializes the table; no word is
// accepted until it completes.
`default_nettype none

module union_find_rank_size_core (
	input  wire logic clk,
	input  wire logic arst_n,
	ufrs_req_if.sink  req,
	ufrs_rsp_if.source rsp
);

	ufrs_pkg::mem_req_t mem_req;
	ufrs_pkg::entry_t   rd_data;
	ufrs_pkg::result_t  res;
	logic               res_valid;
	logic               out_free;
	logic               rsp_valid_q;
	logic               joined_q;
	logic [ufrs_pkg::FIELD_NODE_W-1:0] root_q;
	logic [ufrs_pkg::FIELD_SIZE_W-1:0] size_q;
	logic               size_sat;

	ufrs_store u_store (
		.clk     (clk),
		.req     (mem_req),
		.rd_data (rd_data)
	);

	ufrs_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.op        (req.operation),
		.node_a    (ufrs_pkg::node_t'(req.first_node)),
		.node_b    (ufrs_pkg::node_t'(req.second_node)),
		.out_free  (out_free),
		.res_valid (res_valid),
		.res       (res),
		.mem_req   (mem_req),
		.rd_data   (rd_data)
	);

	// Output register: free when empty or being drained
	assign out_free = !rsp_valid_q || rsp.ready;
	assign size_sat = (32'(res.size) > 32'(ufrs_pkg::SIZE_MAX_OUT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_valid) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Hold the result word; saturate the size to the field
	always_ff @(posedge clk) begin
		if (res_valid) begin
			joined_q <= res.joined;
			root_q   <= ufrs_pkg::FIELD_NODE_W'(res.root);
			size_q   <= size_sat ? ufrs_pkg::FIELD_SIZE_W'(ufrs_pkg::SIZE_MAX_OUT)
				: ufrs_pkg::FIELD_SIZE_W'(res.size);
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.already_joined = joined_q;
	assign rsp.first_root     = root_q;
	assign rsp.first_set_size = size_q;

endmodule

`default_nettype wire

// File: tb/sv/ufrs_tb_pkg.sv
// Operation codes shared by the union-find testbench files.
// Depends on nothing.

package ufrs_tb_pkg;

	typedef enum logic {
		OP_QUERY = 1'b0,
		OP_UNITE = 1'b1
	} uf_op_e;

endpackage

// File: tb/sv/ufrs_set_monitor.sv
// Monitor for the union-find core: tracks its own disjoint-set table, predicts each
// result word and compares it with the response channel. Depends on ufrs_pkg,
// ufrs_tb_pkg and the request/response interfaces.

module ufrs_set_monitor (
	input  wire logic clk,
	input  wire logic arst_n,
	ufrs_req_if       req,
	ufrs_rsp_if       rsp,
	output int        mismatches,
	output int        outstanding
);
	import ufrs_pkg::*;
	import ufrs_tb_pkg::*;

	typedef struct packed {
		logic                    joined;
		logic [FIELD_NODE_W-1:0] root;
		logic [FIELD_SIZE_W-1:0] size;
	} outcome_t;

	node_t    link_tbl [NODE_COUNT];
	rank_t    rank_tbl [NODE_COUNT];
	size_t    size_tbl [NODE_COUNT];
	outcome_t root_size_q [$];
	outcome_t want;
	int       err_cnt = 0;

	// Climb to the root, then relink every node on the path straight to it
	function automatic node_t find_and_compress(node_t start);
		node_t top;
		node_t walk;
		node_t nxt;
		int    steps;
		top = start;
		steps = 0;
		while (link_tbl[top] != top && steps < NODE_COUNT) begin
			top = link_tbl[top];
			steps++;
		end
		walk = start;
		steps = 0;
		while (walk != top && steps < NODE_COUNT) begin
			nxt = link_tbl[walk];
			link_tbl[walk] = top;
			walk = nxt;
			steps++;
		end
		return top;
	endfunction

	// Apply one word to the table and return the result it must produce
	function automatic outcome_t resolve_pair(logic op, node_t a, node_t b);
		node_t       ra;
		node_t       rb;
		node_t       fa;
		logic        joined;
		int unsigned total;
		outcome_t    res;
		ra = find_and_compress(a);
		rb = find_and_compress(b);
		joined = (ra == rb);
		if (op == OP_UNITE && !joined) begin
			// lower rank hangs under the other; a tie goes to the second root
			if (rank_tbl[ra] <= rank_tbl[rb]) begin
				if (rank_tbl[ra] == rank_tbl[rb])
					rank_tbl[rb] = rank_tbl[rb] + 1'b1;
				size_tbl[rb] = size_tbl[rb] + size_tbl[ra];
				link_tbl[ra] = rb;
			end else begin
				size_tbl[ra] = size_tbl[ra] + size_tbl[rb];
				link_tbl[rb] = ra;
			end
		end
		fa = find_and_compress(a);
		total = size_tbl[fa];
		if (total > SIZE_MAX_OUT)
			total = SIZE_MAX_OUT;
		res.joined = joined;
		res.root = fa[FIELD_NODE_W-1:0];
		res.size = total[FIELD_SIZE_W-1:0];
		return res;
	endfunction

	task automatic note_error(string what, int exp_val, int act_val);
		err_cnt++;
		$display("%0t: %s mismatch, expected %0d, got %0d", $time, what, exp_val, act_val);
	endtask

	// Predict on each accepted request, compare on each accepted response
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NODE_COUNT; k++) begin
				link_tbl[k] = node_t'(k);
				rank_tbl[k] = '0;
				size_tbl[k] = size_t'(1);
			end
			root_size_q.delete();
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			if (req.valid && req.ready)
				root_size_q = {root_size_q, resolve_pair(req.operation,
					node_t'(req.first_node), node_t'(req.second_node))};
			if (rsp.valid && rsp.ready) begin
				if (root_size_q.size() == 0) begin
					err_cnt++;
					$display("%0t: result word with none pending, expected nothing, got %0d/%0d/%0d",
						$time, rsp.already_joined, rsp.first_root, rsp.first_set_size);
				end else begin
					want = root_size_q.pop_front();
					if (rsp.already_joined !== want.joined)
						note_error("already_joined", want.joined, rsp.already_joined);
					if (rsp.first_root !== want.root)
						note_error("first_root", want.root, rsp.first_root);
					if (rsp.first_set_size !== want.size)
						note_error("first_set_size", want.size, rsp.first_set_size);
				end
			end
			mismatches <= err_cnt;
			outstanding <= root_size_q.size();
		end
	end

endmodule

// File: tb/sv/tb_union_find_rank_size_core.sv
// Top of the union-find core testbench: clock, reset, request words and verdict.
// Depends on ufrs_pkg, ufrs_tb_pkg, both interfaces, the core and ufrs_set_monitor.

module tb_union_find_rank_size_core;
	import ufrs_pkg::*;
	import ufrs_tb_pkg::*;

	localparam int    CYCLE_LIMIT  = 1000000;
	localparam int    DRAIN_CYCLES = 120;
	localparam int    IDLE_PCT     = 27;
	localparam node_t NODE_TOP     = node_t'(NODE_COUNT - 1);

	logic   clk;
	logic   arst_n;
	bit     idle_on = 1'b1;
	int     cycle_cnt = 0;
	int     mismatches;
	int     outstanding;
	int     unites_sent = 0;
	int     queries_sent = 0;
	int     order [NODE_COUNT];
	int     j;
	int     tmp;
	uf_op_e op;
	node_t  a;
	node_t  b;

	ufrs_req_if req ();
	ufrs_rsp_if rsp ();

	union_find_rank_size_core uut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp)
	);

	ufrs_set_monitor monitor (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.rsp        (rsp),
		.mismatches (mismatches),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Stall the response side at random while idling is on
	initial begin
		rsp.ready <= 1'b0;
		forever begin
			@(posedge clk);
			rsp.ready <= !(idle_on && $urandom_range(99) < IDLE_PCT);
		end
	end

	// Offer one word, idling first at random; return once it is taken
	task automatic send_word(uf_op_e w_op, node_t w_a, node_t w_b);
		while (idle_on && $urandom_range(99) < IDLE_PCT) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.operation <= w_op;
		req.first_node <= w_a;
		req.second_node <= w_b;
		do @(posedge clk); while (!req.ready);
		if (w_op == OP_UNITE)
			unites_sent++;
		else
			queries_sent++;
	endtask

	// Hold the request side low until every result word has come back
	task automatic drain_results();
		req.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	// Random pair: mostly near neighbors (bit flips, short offsets) to grow deep trees
	task automatic pick_pair(output uf_op_e p_op, output node_t p_a, output node_t p_b);
		int    pick;
		node_t swap_n;
		p_op = ($urandom_range(99) < 65) ? OP_UNITE : OP_QUERY;
		p_a = node_t'($urandom_range(NODE_COUNT - 1));
		pick = $urandom_range(3);
		if (pick < 2)
			p_b = p_a ^ (node_t'(1) << $urandom_range(NODE_W - 1));
		else if (pick == 2)
			p_b = p_a + node_t'($urandom_range(15));
		else
			p_b = node_t'($urandom_range(NODE_COUNT - 1));
		if ($urandom_range(1)) begin
			swap_n = p_a;
			p_a = p_b;
			p_b = swap_n;
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		req.valid <= 1'b0;
		req.operation <= OP_QUERY;
		req.first_node <= '0;
		req.second_node <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: field extremes, rank ties and wins, rejoining, compression by query
		send_word(OP_QUERY, '0, '0);
		send_word(OP_QUERY, NODE_TOP, NODE_TOP);
		send_word(OP_QUERY, '0, NODE_TOP);
		send_word(OP_UNITE, node_t'(5), node_t'(5));
		send_word(OP_UNITE, '0, NODE_TOP);
		send_word(OP_UNITE, '0, NODE_TOP);
		send_word(OP_UNITE, NODE_TOP, '0);
		send_word(OP_UNITE, node_t'(1), node_t'(2));
		send_word(OP_UNITE, node_t'(1), '0);
		send_word(OP_UNITE, node_t'(3), node_t'(1));
		send_word(OP_UNITE, NODE_TOP, node_t'(4));
		send_word(OP_QUERY, node_t'(1), node_t'(3));
		send_word(OP_UNITE, node_t'(512), node_t'(511));
		send_word(OP_UNITE, node_t'(510), node_t'(509));
		send_word(OP_UNITE, node_t'(511), node_t'(509));
		send_word(OP_UNITE, node_t'(512), node_t'(1));
		send_word(OP_QUERY, node_t'(510), '0);
		send_word(OP_QUERY, node_t'(1), node_t'(1));
		send_word(OP_QUERY, node_t'(682), node_t'(341));
		send_word(OP_UNITE, node_t'(682), node_t'(341));
		send_word(OP_UNITE, node_t'(341), node_t'(509));
		send_word(OP_QUERY, NODE_TOP, node_t'(682));

		// Random pairs with idling on both sides
		repeat (400) begin
			pick_pair(op, a, b);
			send_word(op, a, b);
		end

		// Let the core run dry once, then a stretch with no idling at all
		drain_results();
		idle_on = 1'b0;
		repeat (350) begin
			pick_pair(op, a, b);
			send_word(op, a, b);
		end
		idle_on = 1'b1;

		// Chain a random permutation so every node ends in one set
		for (int i = 0; i < NODE_COUNT; i++)
			order[i] = i;
		for (int i = NODE_COUNT - 1; i > 0; i--) begin
			j = $urandom_range(i);
			tmp = order[i];
			order[i] = order[j];
			order[j] = tmp;
		end
		for (int i = 1; i < NODE_COUNT; i++) begin
			if ($urandom_range(99) < 20)
				send_word(OP_QUERY, node_t'($urandom_range(NODE_COUNT - 1)),
					node_t'($urandom_range(NODE_COUNT - 1)));
			if ($urandom_range(1))
				send_word(OP_UNITE, node_t'(order[i - 1]), node_t'(order[i]));
			else
				send_word(OP_UNITE, node_t'(order[i]), node_t'(order[i - 1]));
		end
		send_word(OP_QUERY, NODE_TOP, '0);

		// Wait out the last results, then give the verdict
		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Run sent %0d unite and %0d query words: corner pairs, clustered random pairs,",
			unites_sent, queries_sent);
		$display("a drained pause, an idle-free stretch and a full merge into one set.");
		if (mismatches == 0 && outstanding == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
